/* rtl/core/vbfc_pkg.sv */
// ----------------------------------------------------------------------------
// Voxel box fill counter package
// Shared widths and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package vbfc_pkg;

   localparam int COORD_W = 18;
   localparam int COUNT_W = 21;
   localparam int LIT_W   = 20;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_PREP  = 6'b000100,
      ST_SWEEP = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/vbfc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vbfc_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [DATA_W-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output      logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/voxel_box_fill_counter.sv */
// ----------------------------------------------------------------------------
// Voxel box fill counter
// Sets or clears every voxel of a clipped cuboid in a bit volume and returns
// the running count of set voxels after each item.
// ----------------------------------------------------------------------------
//   channel | direction | payload
//   req_    | in        | action, x/y/z low and high bounds (18-bit signed)
//   rsp_    | out       | lit_count (20-bit)
//
// After reset a clearing pass writes zero to every voxel, one per cycle,
// over all (2*HALF_EXTENT+1)^3 voxels (1030301 at the default); req_ready stays low.
// An item visits each of the N voxels of the clipped box (up to
// (2*HALF_EXTENT+1)^3) in turn, with a single read-modify-write per cycle on the
// voxel RAM; an empty box skips the sweep. The result sits in an output
// register; a new item is taken while it waits, and a stalled rsp_ holds
// only the final hand-off of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_box_fill_counter #(
   parameter int HALF_EXTENT = 50
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic                                  req_action,
   input  wire logic signed [vbfc_pkg::COORD_W-1:0]   req_x_low,
   input  wire logic signed [vbfc_pkg::COORD_W-1:0]   req_x_high,
   input  wire logic signed [vbfc_pkg::COORD_W-1:0]   req_y_low,
   input  wire logic signed [vbfc_pkg::COORD_W-1:0]   req_y_high,
   input  wire logic signed [vbfc_pkg::COORD_W-1:0]   req_z_low,
   input  wire logic signed [vbfc_pkg::COORD_W-1:0]   req_z_high,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [vbfc_pkg::LIT_W-1:0]            rsp_lit_count
);

   import vbfc_pkg::*;

   localparam int SIDE   = 2 * HALF_EXTENT + 1;
   localparam int SIDE2  = SIDE * SIDE;
   localparam int VOLUME = SIDE2 * SIDE;
   localparam int CW     = $clog2(SIDE);
   localparam int AW     = $clog2(VOLUME);

   localparam logic signed [COORD_W-1:0] EDGE_HI = COORD_W'(HALF_EXTENT);
   localparam logic signed [COORD_W-1:0] EDGE_LO = COORD_W'(-HALF_EXTENT);

   function automatic logic signed [COORD_W-1:0] clip_lo(logic signed [COORD_W-1:0] v);
      return (v < EDGE_LO) ? EDGE_LO : v;
   endfunction

   function automatic logic signed [COORD_W-1:0] clip_hi(logic signed [COORD_W-1:0] v);
      return (v > EDGE_HI) ? EDGE_HI : v;
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      clear_ff, clear_in;
   logic               action_ff, action_in;
   logic               empty_ff, empty_in;
   logic [CW-1:0]      xl_ff, xl_in, xh_ff, xh_in;
   logic [CW-1:0]      yl_ff, yl_in, yh_ff, yh_in;
   logic [CW-1:0]      zl_ff, zl_in, zh_ff, zh_in;
   logic [CW-1:0]      xc_ff, xc_in, yc_ff, yc_in, zc_ff, zc_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      step_y_ff, step_y_in, step_x_ff, step_x_in;
   logic               pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIT_W-1:0]   lit_ff, lit_in;

   logic signed [COORD_W-1:0] xl_c, xh_c, yl_c, yh_c, zl_c, zh_c;
   logic [COORD_W-1:0]        xl_o, xh_o, yl_o, yh_o, zl_o, zh_o;
   logic [CW-1:0]             dy, dz;
   logic                      x_last, y_last, z_last;
   logic                      ram_we, ram_wdata, ram_rdata;
   logic [AW-1:0]             ram_waddr;

   assign xl_c = clip_lo(req_x_low);
   assign xh_c = clip_hi(req_x_high);
   assign yl_c = clip_lo(req_y_low);
   assign yh_c = clip_hi(req_y_high);
   assign zl_c = clip_lo(req_z_low);
   assign zh_c = clip_hi(req_z_high);

   assign xl_o = xl_c - EDGE_LO;
   assign xh_o = xh_c - EDGE_LO;
   assign yl_o = yl_c - EDGE_LO;
   assign yh_o = yh_c - EDGE_LO;
   assign zl_o = zl_c - EDGE_LO;
   assign zh_o = zh_c - EDGE_LO;

   assign dy = yh_ff - yl_ff;
   assign dz = zh_ff - zl_ff;

   assign x_last = (xc_ff == xh_ff);
   assign y_last = (yc_ff == yh_ff);
   assign z_last = (zc_ff == zh_ff);

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lit_count = lit_ff;

   assign ram_we    = (state_ff == ST_CLEAR) || pipe_valid_ff;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clear_ff : wr_addr_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? 1'b0 : action_ff;

   vbfc_ram #(
      .DATA_W (1),
      .DEPTH  (VOLUME)
   ) u_voxels (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      action_in     = action_ff;
      empty_in      = empty_ff;
      xl_in         = xl_ff;
      xh_in         = xh_ff;
      yl_in         = yl_ff;
      yh_in         = yh_ff;
      zl_in         = zl_ff;
      zh_in         = zh_ff;
      xc_in         = xc_ff;
      yc_in         = yc_ff;
      zc_in         = zc_ff;
      addr_in       = addr_ff;
      step_y_in     = step_y_ff;
      step_x_in     = step_x_ff;
      pipe_valid_in = 1'b0;
      wr_addr_in    = addr_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      lit_in        = lit_ff;

      // update the count from the voxel read in the previous cycle
      if (pipe_valid_ff) begin
         if (action_ff && !ram_rdata) begin
            count_in = count_ff + COUNT_W'(1);
         end else if (!action_ff && ram_rdata) begin
            count_in = count_ff - COUNT_W'(1);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + AW'(1);
            if (clear_ff == AW'(VOLUME - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               empty_in  = (xl_c > xh_c) || (yl_c > yh_c) || (zl_c > zh_c);
               xl_in     = xl_o[CW-1:0];
               xh_in     = xh_o[CW-1:0];
               yl_in     = yl_o[CW-1:0];
               yh_in     = yh_o[CW-1:0];
               zl_in     = zl_o[CW-1:0];
               zh_in     = zh_o[CW-1:0];
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            xc_in     = xl_ff;
            yc_in     = yl_ff;
            zc_in     = zl_ff;
            addr_in   = AW'(xl_ff) * AW'(SIDE2) + AW'(yl_ff) * AW'(SIDE) + AW'(zl_ff);
            step_y_in = AW'(SIDE) - AW'(dz);
            step_x_in = AW'(SIDE2) - AW'(dy) * AW'(SIDE) - AW'(dz);
            state_in  = empty_ff ? ST_DONE : ST_SWEEP;
         end
         ST_SWEEP: begin
            pipe_valid_in = 1'b1;
            if (!z_last) begin
               zc_in   = zc_ff + CW'(1);
               addr_in = addr_ff + AW'(1);
            end else if (!y_last) begin
               zc_in   = zl_ff;
               yc_in   = yc_ff + CW'(1);
               addr_in = addr_ff + step_y_ff;
            end else begin
               zc_in   = zl_ff;
               yc_in   = yl_ff;
               xc_in   = xc_ff + CW'(1);
               addr_in = addr_ff + step_x_ff;
               if (x_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               lit_in       = count_ff[LIT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ff      <= '0;
         pipe_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         pipe_valid_ff <= pipe_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      action_ff  <= action_in;
      empty_ff   <= empty_in;
      xl_ff      <= xl_in;
      xh_ff      <= xh_in;
      yl_ff      <= yl_in;
      yh_ff      <= yh_in;
      zl_ff      <= zl_in;
      zh_ff      <= zh_in;
      xc_ff      <= xc_in;
      yc_ff      <= yc_in;
      zc_ff      <= zc_in;
      addr_ff    <= addr_in;
      step_y_ff  <= step_y_in;
      step_x_ff  <= step_x_in;
      wr_addr_ff <= wr_addr_in;
      lit_ff     <= lit_in;
   end

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel box fill counter testbench
// Drives cuboid set/clear items into the block and checks each returned
// lit_count against a bit-level occupancy model of the same voxel volume.
// Directed items cover the bound extremes, clipping, empty and outside boxes
// and a full-volume fill. Random items follow; idle bursts on both sides run until the last N_CALM items.
// ----------------------------------------------------------------------------

localparam int HALF   = 50;
localparam int SIDE   = 2 * HALF + 1;
localparam int VOLUME = SIDE * SIDE * SIDE;

typedef struct {
   bit                                 action;
   bit signed [vbfc_pkg::COORD_W-1:0]  xl, xh, yl, yh, zl, zh;
} box_type;

class voxel_occupancy;
   bit                           voxels[];
   bit [vbfc_pkg::COUNT_W-1:0]   lit_total;
   bit [vbfc_pkg::LIT_W-1:0]     lit_count_q[$];
   int                           mismatches;

   function new();
      voxels     = new[VOLUME];
      lit_total  = '0;
      mismatches = 0;
   endfunction

   static function int clip_span(int lo, int hi, output int first, output int last);
      first = (lo < -HALF) ? -HALF : lo;
      last  = (hi > HALF) ? HALF : hi;
      return (first <= last) ? last - first + 1 : 0;
   endfunction

   function void note_box(box_type b);
      int x0, x1, y0, y1, z0, z1, nx, ny, nz, idx;
      nx = clip_span(int'(b.xl), int'(b.xh), x0, x1);
      ny = clip_span(int'(b.yl), int'(b.yh), y0, y1);
      nz = clip_span(int'(b.zl), int'(b.zh), z0, z1);
      if (nx > 0 && ny > 0 && nz > 0) begin
         for (int x = x0; x <= x1; x++) begin
            for (int y = y0; y <= y1; y++) begin
               for (int z = z0; z <= z1; z++) begin
                  idx = ((x + HALF) * SIDE + (y + HALF)) * SIDE + (z + HALF);
                  if (voxels[idx] != b.action) begin
                     voxels[idx] = b.action;
                     lit_total   = b.action ? lit_total + 1'b1 : lit_total - 1'b1;
                  end
               end
            end
         end
      end
      lit_count_q.push_back(lit_total[vbfc_pkg::LIT_W-1:0]);
   endfunction

   function void check_count(bit [vbfc_pkg::LIT_W-1:0] actual);
      bit [vbfc_pkg::LIT_W-1:0] expected;
      if (lit_count_q.size() == 0) begin
         $error("lit_count: expected none, actual %0d", actual);
         mismatches++;
      end else begin
         expected = lit_count_q.pop_front();
         if (expected != actual) begin
            $error("lit_count: expected %0d, actual %0d", expected, actual);
            mismatches++;
         end
      end
   endfunction

   function int pending();
      return lit_count_q.size();
   endfunction
endclass

module tb;

   import vbfc_pkg::*;

   localparam int N_RANDOM = 80;
   localparam int N_CALM   = 20;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_action;
   logic signed [vbfc_pkg::COORD_W-1:0]  req_x_low, req_x_high;
   logic signed [vbfc_pkg::COORD_W-1:0]  req_y_low, req_y_high;
   logic signed [vbfc_pkg::COORD_W-1:0]  req_z_low, req_z_high;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [vbfc_pkg::LIT_W-1:0]           rsp_lit_count;

   voxel_occupancy sb = new();
   box_type        stimulus_q[$];
   bit             calm = 1'b0;

   voxel_box_fill_counter #(.HALF_EXTENT(HALF)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_x_low     (req_x_low),
      .req_x_high    (req_x_high),
      .req_y_low     (req_y_low),
      .req_y_high    (req_y_high),
      .req_z_low     (req_z_low),
      .req_z_high    (req_z_high),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lit_count (rsp_lit_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic box_type mk_box(bit act, int xl, int xh, int yl, int yh, int zl, int zh);
      box_type b;
      b.action = act;
      b.xl = COORD_W'(xl); b.xh = COORD_W'(xh);
      b.yl = COORD_W'(yl); b.yh = COORD_W'(yh);
      b.zl = COORD_W'(zl); b.zh = COORD_W'(zh);
      return b;
   endfunction

   task automatic send_box(input box_type b);
      @(negedge clock);
      req_valid  = 1'b1;
      req_action = b.action;
      req_x_low  = b.xl;
      req_x_high = b.xh;
      req_y_low  = b.yl;
      req_y_high = b.yh;
      req_z_low  = b.zl;
      req_z_high = b.zh;
      do @(posedge clock); while (!req_ready);
      sb.note_box(b);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_count(rsp_lit_count);
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   end

   initial begin
      #240_000_000;
      $display("voxel_box_fill_counter: mismatch");
      $finish;
   end

   initial begin
      int                                lo[3], hi[3];
      int                                kind, axis, n, d0, d1;
      bit                                act;
      bit signed [vbfc_pkg::COORD_W-1:0] raw;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = 1'b0;
      req_x_low  = '0;
      req_x_high = '0;
      req_y_low  = '0;
      req_y_high = '0;
      req_z_low  = '0;
      req_z_high = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty, outside and saturated-bound boxes, clipped boxes, clears and a full-volume fill
      stimulus_q.push_back(mk_box(1'b1, 5, 4, 0, 0, 0, 0));
      stimulus_q.push_back(mk_box(1'b1, 51, 100, 0, 0, 0, 0));
      stimulus_q.push_back(mk_box(1'b1, 0, 0, 0, 0, -80, -51));
      stimulus_q.push_back(mk_box(1'b1, -131072, -131072, -131072, -131072, -131072, -131072));
      stimulus_q.push_back(mk_box(1'b1, 131071, 131071, 131071, 131071, 131071, 131071));
      stimulus_q.push_back(mk_box(1'b1, 0, 0, 0, 0, 0, 0));
      stimulus_q.push_back(mk_box(1'b1, -131072, -50, -50, -50, -50, -50));
      stimulus_q.push_back(mk_box(1'b1, 50, 131071, 50, 50, 50, 50));
      stimulus_q.push_back(mk_box(1'b1, -131072, 131071, 0, 0, 0, 0));
      stimulus_q.push_back(mk_box(1'b1, 0, 0, -131072, 131071, 0, 0));
      stimulus_q.push_back(mk_box(1'b1, 0, 0, 0, 0, -131072, 131071));
      stimulus_q.push_back(mk_box(1'b0, 0, 0, 0, 0, 0, 0));
      stimulus_q.push_back(mk_box(1'b0, 0, 0, 0, 0, 0, 0));
      stimulus_q.push_back(mk_box(1'b0, 10, 10, 3, 2, 10, 10));
      stimulus_q.push_back(mk_box(1'b1, -2, 0, -2, 0, -2, 0));
      stimulus_q.push_back(mk_box(1'b0, -1, 1, -1, 1, -1, 1));
      stimulus_q.push_back(mk_box(1'b1, 48, 52, -52, -48, 48, 131071));
      stimulus_q.push_back(mk_box(1'b1, -131072, 131071, -131072, 131071, -131072, 131071));
      stimulus_q.push_back(mk_box(1'b0, -5, 4, -5, 4, -5, 4));
      stimulus_q.push_back(mk_box(1'b0, -131072, 131071, 7, 7, -131072, 131071));

      for (int i = 0; i < N_RANDOM; i++) begin
         act  = 1'($urandom_range(0, 1));
         kind = $urandom_range(0, 9);
         for (int a = 0; a < 3; a++) begin
            lo[a] = int'($urandom_range(0, 2 * HALF)) - HALF;
            hi[a] = lo[a] + int'($urandom_range(0, 7));
         end
         axis = $urandom_range(0, 2);
         case (kind)
            7: begin
               hi[axis] = lo[axis] - 1 - int'($urandom_range(0, 20));
            end
            8: begin
               do begin
                  for (int a = 0; a < 3; a++) begin
                     raw   = COORD_W'($urandom);
                     lo[a] = int'(raw);
                     raw   = COORD_W'($urandom);
                     hi[a] = int'(raw);
                  end
                  n = sb.clip_span(lo[0], hi[0], d0, d1)
                      * sb.clip_span(lo[1], hi[1], d0, d1)
                      * sb.clip_span(lo[2], hi[2], d0, d1);
               end while (n > 30000);
            end
            9: begin
               lo[axis] = -int'($urandom_range(HALF, 131072));
               hi[axis] = int'($urandom_range(HALF, 131071));
            end
            default: begin
            end
         endcase
         stimulus_q.push_back(mk_box(act, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]));
      end

      foreach (stimulus_q[i]) begin
         if (i >= stimulus_q.size() - N_CALM)
            calm = 1'b1;
         send_box(stimulus_q[i]);
         if (!calm && $urandom_range(0, 2) == 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("voxel_box_fill_counter: match");
      else
         $display("voxel_box_fill_counter: mismatch");
      $finish;
   end

endmodule
